### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on the rising edge of clk
// and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the following cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/utf8d_pkg.sv
package utf8d_pkg;

    localparam int CP_W   = 21;
    localparam int PEND_W = 2;

    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

    typedef struct packed {
        logic              emit;
        logic [CP_W-1:0]   code_point;
        logic [CP_W-1:0]   partial_value;
        logic [PEND_W-1:0] bytes_pending;
    } step_t;

    // One byte of decoding: new decoder state and the code point it completes.
    function automatic step_t decode_step(
        input logic [7:0]        b,
        input logic              last,
        input logic [CP_W-1:0]   partial_value,
        input logic [PEND_W-1:0] bytes_pending
    );
        step_t             s;
        logic [CP_W-1:0]   shifted;
        logic [PEND_W-1:0] pend_dec;
        s.emit          = 1'b0;
        s.code_point    = {CP_W{1'b0}};
        s.partial_value = partial_value;
        s.bytes_pending = bytes_pending;
        shifted  = {partial_value[CP_W-7:0], b[5:0]};
        pend_dec = bytes_pending - PEND_ONE;
        if (b[7:6] == CONT_TAG)
        begin
            if (bytes_pending != PEND_NONE)
            begin
                s.bytes_pending = pend_dec;
                if (pend_dec == PEND_NONE)
                begin
                    s.emit          = 1'b1;
                    s.code_point    = shifted;
                    s.partial_value = {CP_W{1'b0}};
                end
                else
                begin
                    s.partial_value = shifted;
                end
            end
        end
        else
        begin
            // Any non-continuation byte drops an open sequence and acts as a lead.
            s.partial_value = {CP_W{1'b0}};
            s.bytes_pending = PEND_NONE;
            if (!b[7])
            begin
                s.emit       = 1'b1;
                s.code_point = {{(CP_W-8){1'b0}}, b};
            end
            else if (b[7:5] == LEAD2_TAG)
            begin
                s.partial_value = {{(CP_W-5){1'b0}}, b[4:0]};
                s.bytes_pending = PEND_ONE;
            end
            else if (b[7:4] == LEAD3_TAG)
            begin
                s.partial_value = {{(CP_W-4){1'b0}}, b[3:0]};
                s.bytes_pending = PEND_TWO;
            end
            else if (b[7:3] == LEAD4_TAG)
            begin
                s.partial_value = {{(CP_W-3){1'b0}}, b[2:0]};
                s.bytes_pending = PEND_THREE;
            end
        end
        if (last)
        begin
            s.partial_value = {CP_W{1'b0}};
            s.bytes_pending = PEND_NONE;
        end
        return s;
    endfunction

endpackage

### hw/rtl/utf8_stream_decoder.sv
// Channel   Handshake               Payload
// -------   ---------------------   -----------------------------
// byte in   byte_valid / byte_stall  data_byte[7:0], end_of_text
// cp out    cp_valid / cp_stall      code_point[20:0]
//
// One byte is taken every clock while byte_stall is low; a completed code
// point appears in the cycle after the byte that finishes it, held in the
// result register. The decode step is a single shallow pass from the state
// registers and the incoming byte into the state and result registers.
// Reset clears the open sequence and the result valid flag.
// byte_stall rises only while a result waits and cp_stall is high.
`include "assert_macros.svh"

module utf8_stream_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    output logic                          byte_stall,
    input  logic [7:0]                    data_byte,
    input  logic                          end_of_text,
    output logic                          cp_valid,
    input  logic                          cp_stall,
    output logic [utf8d_pkg::CP_W-1:0]    code_point
);

    logic [utf8d_pkg::CP_W-1:0]   partial_reg;
    logic [utf8d_pkg::CP_W-1:0]   partial_next;
    logic [utf8d_pkg::PEND_W-1:0] pending_reg;
    logic [utf8d_pkg::PEND_W-1:0] pending_next;
    logic                         cp_valid_reg;
    logic                         cp_valid_next;
    logic [utf8d_pkg::CP_W-1:0]   cp_reg;
    logic [utf8d_pkg::CP_W-1:0]   cp_next;
    logic                         accept;
    logic                         out_free;
    utf8d_pkg::step_t             step;

    assign out_free   = !cp_valid_reg || !cp_stall;
    assign byte_stall = !out_free;
    assign accept     = byte_valid && out_free;

    assign step = utf8d_pkg::decode_step(data_byte, end_of_text, partial_reg, pending_reg);

    always_comb
    begin
        partial_next  = partial_reg;
        pending_next  = pending_reg;
        cp_valid_next = cp_valid_reg && cp_stall;
        cp_next       = cp_reg;
        if (accept)
        begin
            partial_next  = step.partial_value;
            pending_next  = step.bytes_pending;
            cp_valid_next = step.emit;
            if (step.emit)
            begin
                cp_next = step.code_point;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg  <= '0;
            pending_reg  <= utf8d_pkg::PEND_NONE;
            cp_valid_reg <= 1'b0;
        end
        else
        begin
            partial_reg  <= partial_next;
            pending_reg  <= pending_next;
            cp_valid_reg <= cp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg <= cp_next;
    end

    assign cp_valid   = cp_valid_reg;
    assign code_point = cp_reg;

    `ASSERT_ALWAYS(a_idle_partial_zero,
        (pending_reg != utf8d_pkg::PEND_NONE) || (partial_reg == '0),
        "partial value left over with no sequence open")
    `ASSERT_NEXT(a_end_clears,
        accept && end_of_text,
        (pending_reg == utf8d_pkg::PEND_NONE) && (partial_reg == '0),
        "state not cleared after the final beat of the text")
    `ASSERT_NEXT(a_ascii_passes,
        accept && !data_byte[7],
        cp_valid_reg && (cp_reg == {{(utf8d_pkg::CP_W-8){1'b0}}, $past(data_byte)}),
        "ASCII byte not delivered as a code point")

endmodule
